// File: rtl/core/ghc_pkg.sv
// Shared types and constants for the greedy hypergraph coloring block.
package ghc_pkg;

  localparam int VERTEX_W = 5;
  localparam int COLOR_W  = 6;
  localparam int MODE_W   = 2;
  // Highest vertex count that the vertex field can address
  localparam int VERTEX_SPAN = 1 << VERTEX_W;

  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
  // Spare code: accepted and ignored
  localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [VERTEX_W-1:0] vertex;
    logic                edge_end;
  } ghc_in_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex_out;
    logic [COLOR_W-1:0]  color;
    logic                last;
  } ghc_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK
  } ghc_state_t;

  typedef struct packed {
    logic add;
    logic clr;
    logic start;
    logic scan;
    logic pick;
  } ghc_cmd_t;

  typedef struct packed {
    logic any_vertex;
    logic is_last;
    logic slot_free;
  } ghc_stat_t;

endpackage

// File: rtl/core/ghc_ctrl.sv
// Controller state machine: accepts transactions and sequences the coloring run.
module ghc_ctrl import ghc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [MODE_W-1:0] in_mode,
  input  ghc_stat_t         stat,
  output logic              in_ready,
  output ghc_cmd_t          cmd
);

  ghc_state_t state_r, state_nxt;

  // Hold or advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_mode == MODE_RUN && stat.any_vertex) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (stat.slot_free) begin
          state_nxt = stat.is_last ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_mode)
            MODE_ADD:   cmd.add   = 1'b1;
            MODE_CLEAR: cmd.clr   = 1'b1;
            MODE_RUN:   cmd.start = stat.any_vertex;
            default:    ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_PICK: begin
        cmd.pick = stat.slot_free;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/ghc_datapath.sv
// Datapath: adjacency matrix, open hyperedge, color classes and result register.
module ghc_datapath import ghc_pkg::*; #(
  parameter int NUM_ROWS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ghc_cmd_t  cmd,
  input  ghc_in_t   in_data,
  input  logic      out_ready,
  output ghc_stat_t stat,
  output logic      out_valid,
  output ghc_out_t  out_data
);

  localparam int VW = $clog2(NUM_ROWS);

  logic [NUM_ROWS-1:0] adj_r   [NUM_ROWS];
  logic [NUM_ROWS-1:0] adj_nxt [NUM_ROWS];
  // Color class c holds the vertices colored c+1 in the current run
  logic [NUM_ROWS-1:0] class_r [NUM_ROWS];
  logic [NUM_ROWS-1:0] edge_r, edge_nxt;
  logic [VW-1:0]       highest_r;
  logic                any_r;
  logic [VW-1:0]       idx_r;
  logic [NUM_ROWS-1:0] used_r, used_nxt;
  logic                out_valid_r;
  ghc_out_t            out_data_r;

  logic                v_ok;
  logic                add_ok;
  logic [VW-1:0]       v_idx;
  logic [NUM_ROWS-1:0] v_hot;
  logic [NUM_ROWS-1:0] lower_mask;
  logic [NUM_ROWS-1:0] row_low;
  logic [VW-1:0]       free_idx;
  logic                found;
  logic                is_last;
  logic                slot_free;

  // Decode the member vertex
  always_comb begin
    v_ok   = {1'b0, in_data.vertex} < (VERTEX_W + 1)'(NUM_ROWS);
    v_idx  = in_data.vertex[VW-1:0];
    add_ok = cmd.add && v_ok;
    v_hot  = '0;
    v_hot[v_idx] = 1'b1;
  end

  // Join the new member to every open member, both directions
  always_comb begin
    for (int u = 0; u < NUM_ROWS; u++) begin
      adj_nxt[u] = adj_r[u];
      if (add_ok && edge_r[u] && VW'(u) != v_idx) begin
        adj_nxt[u] = adj_r[u] | v_hot;
      end
      if (add_ok && VW'(u) == v_idx) begin
        adj_nxt[u] = adj_r[u] | (edge_r & ~v_hot);
      end
    end
  end

  always_comb begin
    edge_nxt = edge_r;
    if (add_ok) begin
      edge_nxt = edge_r | v_hot;
    end
    if (cmd.add && in_data.edge_end) begin
      edge_nxt = '0;
    end
  end

  // Graph state: cleared by reset and by the clear command
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      for (int u = 0; u < NUM_ROWS; u++) begin
        adj_r[u] <= '0;
      end
      edge_r    <= '0;
      highest_r <= '0;
      any_r     <= 1'b0;
    end else begin
      adj_r  <= adj_nxt;
      edge_r <= edge_nxt;
      if (add_ok) begin
        if (!any_r || v_idx > highest_r) begin
          highest_r <= v_idx;
        end
        any_r <= 1'b1;
      end
    end
  end

  // Collect colors held by lower-indexed neighbors of the current vertex
  always_comb begin
    lower_mask = (NUM_ROWS'(1) << idx_r) - NUM_ROWS'(1);
    row_low    = adj_r[idx_r] & lower_mask;
    for (int c = 0; c < NUM_ROWS; c++) begin
      used_nxt[c] = |(class_r[c] & row_low);
    end
  end

  // Find the smallest free color
  always_comb begin
    free_idx = '0;
    found    = 1'b0;
    for (int c = 0; c < NUM_ROWS; c++) begin
      if (!found && !used_r[c]) begin
        free_idx = VW'(c);
        found    = 1'b1;
      end
    end
  end

  assign is_last   = idx_r == highest_r;
  assign slot_free = !out_valid_r || out_ready;

  // Vertex counter and used-color register
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx_r <= '0;
    end else if (cmd.pick && !is_last) begin
      idx_r <= idx_r + VW'(1);
    end
    if (cmd.scan) begin
      used_r <= used_nxt;
    end
  end

  // Move the current vertex into its new color class
  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      for (int c = 0; c < NUM_ROWS; c++) begin
        class_r[c][idx_r] <= VW'(c) == free_idx;
      end
    end
  end

  // Result register: load on pick, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.pick) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      out_data_r.vertex_out <= VERTEX_W'(idx_r);
      out_data_r.color      <= COLOR_W'(free_idx) + COLOR_W'(1);
      out_data_r.last       <= is_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign stat.any_vertex = any_r;
  assign stat.is_last    = is_last;
  assign stat.slot_free  = slot_free;

endmodule

// File: rtl/core/greedy_hypergraph_coloring.sv
// Greedy first-fit coloring of a hypergraph's clique expansion. An add transaction
// (mode 0) joins one member vertex to the open hyperedge; edge_end closes the
// hyperedge. A clear transaction is mode 2. A run transaction (mode 1) colors
// vertices 0 up to the highest vertex seen and emits one result each, the last one
// flagged. For each vertex the scan state forms its set of used colors from its
// adjacency row and the color-class registers, and the pick state picks the lowest
// free color and loads the result register, waiting while it holds an untaken result.
// The result register parts the two sides, so a finished result may wait while the
// next transaction is taken.
module greedy_hypergraph_coloring import ghc_pkg::*; #(
  parameter int MAX_VERTICES = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ghc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ghc_out_t out_data
);

  // Only vertices the input field can address get storage
  localparam int NUM_ROWS = (MAX_VERTICES < VERTEX_SPAN) ? MAX_VERTICES : VERTEX_SPAN;

  ghc_cmd_t  cmd;
  ghc_stat_t stat;

  ghc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  ghc_datapath #(
    .NUM_ROWS (NUM_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_ready (out_ready),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/ghc_checker.sv
// Port-level checker for the coloring block and its bind to the top level.
module ghc_checker import ghc_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input ghc_out_t out_data
);

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // While a run is still producing results, no input is taken
  a_busy_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> !in_ready)
    else $error("input ready in the middle of a run");

  // Colors start at one
  a_color_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.color != '0)
    else $error("zero color emitted");

  // Vertex zero always gets the first color
  a_vertex0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.vertex_out == '0 |-> out_data.color == COLOR_W'(1))
    else $error("vertex zero not given color one");

endmodule

bind greedy_hypergraph_coloring ghc_checker u_ghc_checker (.*);

// File: test/tb.sv
// Self-checking testbench for the greedy hypergraph coloring block.
module tb import ghc_pkg::*;;

  localparam int NV = 32;
  localparam int RANDOM_ITEMS = 100;
  localparam int END_SETTLE = 4 * NV;
  localparam int RUN_LIMIT = 2000000;

  // Predict colorings and hold the results still to come out
  class coloring_scoreboard;
    logic [NV-1:0]      adj_row [NV];
    logic [NV-1:0]      open_edge;
    logic [VERTEX_W-1:0] top_vertex;
    bit                 seen_any;
    logic [COLOR_W-1:0] color_of [NV];
    ghc_out_t           color_q [$];
    int                 errors;
    int                 mismatches;

    function new();
      errors = 0;
      mismatches = 0;
      clear_graph();
    endfunction

    function void clear_graph();
      for (int u = 0; u < NV; u++) adj_row[u] = '0;
      open_edge = '0;
      top_vertex = '0;
      seen_any = 0;
    endfunction

    function logic [COLOR_W-1:0] first_free(int v);
      logic [63:0] used;
      used = '0;
      for (int j = 0; j < v; j++) begin
        if (adj_row[v][j]) used[color_of[j] - 1] = 1'b1;
      end
      for (int k = 0; k < 64; k++) begin
        if (!used[k]) return COLOR_W'(k + 1);
      end
      return COLOR_W'(64);
    endfunction

    // Update the graph copy and queue the results of one accepted transaction
    function void note_input(ghc_in_t item);
      ghc_out_t res;
      int v;
      v = item.vertex;
      case (item.mode)
        MODE_ADD: begin
          if (v < NV) begin
            for (int u = 0; u < NV; u++) begin
              if (u != v && open_edge[u]) begin
                adj_row[u][v] = 1'b1;
                adj_row[v][u] = 1'b1;
              end
            end
            open_edge[v] = 1'b1;
            if (!seen_any || item.vertex > top_vertex) top_vertex = item.vertex;
            seen_any = 1;
          end
          if (item.edge_end) open_edge = '0;
        end
        MODE_RUN: begin
          if (seen_any) begin
            for (int i = 0; i <= top_vertex; i++) begin
              color_of[i] = (i == 0) ? COLOR_W'(1) : first_free(i);
              res.vertex_out = VERTEX_W'(i);
              res.color = color_of[i];
              res.last = (i == top_vertex);
              color_q = {color_q, res};
            end
          end
        end
        MODE_CLEAR: clear_graph();
        default: ;
      endcase
    endfunction

    function void flag(string what, ghc_out_t want, ghc_out_t got);
      errors++;
      mismatches++;
      if (mismatches <= 10)
        $display("%0t %s: expected %0d/%0d/%0b, got %0d/%0d/%0b (vertex/color/last)",
                 $time, what, want.vertex_out, want.color, want.last,
                 got.vertex_out, got.color, got.last);
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(ghc_out_t got);
      ghc_out_t want;
      if (color_q.size() == 0) begin
        want = '0;
        flag("unexpected result", want, got);
        return;
      end
      want = color_q.pop_front();
      if (got.vertex_out !== want.vertex_out || got.color !== want.color ||
          got.last !== want.last)
        flag("result mismatch", want, got);
    endfunction

    function int pending();
      return color_q.size();
    endfunction
  endclass

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  ghc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ghc_out_t out_data;

  coloring_scoreboard sb = new();

  int burst_left = 0;
  bit steady_phase = 0;
  logic [7:0] ready_cycle = '0;
  logic [1:0] ready_style = '0;

  greedy_hypergraph_coloring #(.MAX_VERTICES(NV)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel on a random pattern, chosen anew whenever ready_cycle[5:0] is zero
  always @(posedge clk) begin
    ready_cycle <= ready_cycle + 1'b1;
    if (ready_cycle[5:0] == 6'd0) ready_style <= 2'($urandom_range(0, 3));
    case (ready_style)
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 1) == 1);
      2'd2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= (ready_cycle[2:0] != 3'd0);
    endcase
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  function automatic ghc_in_t make_item(logic [MODE_W-1:0] m, logic [VERTEX_W-1:0] v,
                                        logic e);
    ghc_in_t t;
    t.mode = m;
    t.vertex = v;
    t.edge_end = e;
    return t;
  endfunction

  // Hold the transaction until the block takes it
  task automatic send_item(input ghc_in_t item);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_input(item);
  endtask

  task automatic idle(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Send in bursts, with a gap after each burst unless in a steady stretch
  task automatic put_item(input ghc_in_t item);
    send_item(item);
    if (burst_left == 0) begin
      if (!steady_phase) idle($urandom_range(1, 6));
      burst_left = $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  // Pause the sender until every predicted result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_hyperedge(output int sent);
    int size;
    int span;
    size = $urandom_range(1, 5);
    span = ($urandom_range(0, 3) == 0) ? 31 : 7;
    for (int m = 0; m < size; m++)
      put_item(make_item(MODE_ADD, VERTEX_W'($urandom_range(0, span)), m == size - 1));
    sent = size;
  endtask

  initial begin
    int sent;
    int count;
    int pick;
    bit paused;
    ghc_in_t noise;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty graph, lone vertex 0, extremes, repeats, open edge, clear
    put_item(make_item(MODE_RUN, 5'd31, 1'b1));
    put_item(make_item(MODE_ADD, 5'd0, 1'b1));
    put_item(make_item(MODE_RUN, 5'd0, 1'b0));
    drain();
    put_item(make_item(MODE_CLEAR, 5'd17, 1'b1));
    put_item(make_item(MODE_ADD, 5'd31, 1'b0));
    put_item(make_item(MODE_ADD, 5'd0, 1'b0));
    put_item(make_item(MODE_ADD, 5'd5, 1'b0));
    put_item(make_item(MODE_ADD, 5'd5, 1'b1));
    put_item(make_item(MODE_NOP, 5'd31, 1'b1));
    put_item(make_item(MODE_ADD, 5'd3, 1'b0));
    put_item(make_item(MODE_RUN, 5'd21, 1'b1));
    put_item(make_item(MODE_ADD, 5'd7, 1'b1));
    put_item(make_item(MODE_ADD, 5'd7, 1'b0));
    put_item(make_item(MODE_ADD, 5'd31, 1'b0));
    put_item(make_item(MODE_ADD, 5'd16, 1'b1));
    put_item(make_item(MODE_RUN, 5'd0, 1'b0));
    put_item(make_item(MODE_CLEAR, 5'd0, 1'b0));
    put_item(make_item(MODE_RUN, 5'd10, 1'b0));
    put_item(make_item(MODE_NOP, 5'd0, 1'b0));

    // Random: mostly well-formed hyperedges, with runs, clears and noise
    count = 0;
    paused = 0;
    while (count < RANDOM_ITEMS) begin
      if (count % 20 == 0) steady_phase = ($urandom_range(0, 2) == 0);
      if (!paused && count >= RANDOM_ITEMS / 2) begin
        drain();
        paused = 1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_hyperedge(sent);
        count += sent;
      end else if (pick < 80) begin
        put_item(make_item(MODE_RUN, VERTEX_W'($urandom), 1'($urandom)));
        count++;
      end else if (pick < 86) begin
        put_item(make_item(MODE_CLEAR, VERTEX_W'($urandom), 1'($urandom)));
        count++;
      end else if (pick < 93) begin
        noise = make_item(MODE_NOP, VERTEX_W'($urandom), 1'($urandom));
        put_item(noise);
      end else begin
        put_item(make_item(MODE_ADD, VERTEX_W'($urandom), 1'($urandom)));
        count++;
      end
    end
    put_item(make_item(MODE_RUN, 5'd0, 1'b0));

    // Wait out the remaining results, then let the block settle
    drain();
    repeat (END_SETTLE) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors += sb.pending();
      $display("%0t %0d predicted results never arrived", $time, sb.pending());
    end
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #(RUN_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
